@@ rtl/hbs_pkg.sv @@
package hbs_pkg;

	localparam int MAX_BUCKETS_DEF = 64;
	localparam int COUNT_BITS_DEF  = 32;
	localparam int ADDR_W          = 4;

	localparam logic [15:0] X_LOW_RST          = 16'd0;
	localparam logic [15:0] BIN_SPAN_RST       = 16'd2;
	localparam logic [6:0]  BUCKETS_IN_USE_RST = 7'd50;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_READ   = 2'd2,
		MODE_REPORT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_X_LOW          = 2'd0,
		REG_BIN_SPAN       = 2'd1,
		REG_BUCKETS_IN_USE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] sample;
		logic [5:0]  bucket_select;
	} item_t;

	typedef struct packed {
		logic [5:0]  bucket_index;
		logic [31:0] bucket_count;
		logic        out_of_range;
		logic [31:0] total_count;
		logic [39:0] mean_count;
		logic [39:0] std_deviation;
	} result_t;

endpackage

@@ rtl/histogram_binning_stats.sv @@
// Fixed-width bucket histogram with total, mean and standard deviation report.
// Item channel (item_valid/item_stall/item): one transaction per command, the
// mode field selects sample, clear, read of one bucket, or report. Result
// channel (result_valid/result_stall/result): exactly one transaction per item.
// Settings (x_low, bin_span, buckets_in_use) are written over the APB port; the
// user must write them while the block is idle (the block does not enforce it);
// pready is tied high, reads return the register. One item at a time (item_stall
// high while busy): sample does 16 restoring divide steps by the bucket width;
// read is one bucket memory read; clear zeroes all MAX_BUCKETS buckets; report
// sweeps the N buckets in use, then does mean divide, multiply of the square sum
// by N, square of the sum, subtract, divide by N, divide by N again and a square
// root. Apart from squaring each count in its own multiplier, all of it runs
// through one shared wide add/subtract unit (sums, shift-add multiply, divide, square root).
// After reset a clearing pass zeroes the bucket memory; item_stall stays high
// until it is done. A finished result sits in an output register; a new item
// is taken while it waits, and the next result is held back until the
// receiver lifts result_stall.
module histogram_binning_stats #(
	parameter int MAX_BUCKETS = hbs_pkg::MAX_BUCKETS_DEF,
	parameter int COUNT_BITS  = hbs_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  hbs_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output hbs_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hbs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	import hbs_pkg::*;

	localparam int IW  = $clog2(MAX_BUCKETS);
	localparam int NW  = $clog2(MAX_BUCKETS + 1);
	localparam int S1W = COUNT_BITS + NW;
	localparam int SQW = 2 * COUNT_BITS;
	localparam int S2W = SQW + NW;
	localparam int MW  = S1W + 8;
	localparam int AW  = S2W + NW + 16;
	localparam int RW  = AW / 2;
	localparam int CW  = $clog2(AW + 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BIN_DIV,
		ST_BIN_CHECK,
		ST_BIN_READ,
		ST_BIN_INC,
		ST_RD_WAIT,
		ST_RD_TAKE,
		ST_SW_ADDR,
		ST_SW_SUM1,
		ST_SW_SUM2,
		ST_MEAN_DIV,
		ST_MUL_N,
		ST_MUL_S1,
		ST_NUM_SUB,
		ST_DIV_N1,
		ST_DIV_N2,
		ST_SQRT,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [NW-1:0]     ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              result_valid_q;
	result_t           result_q;
	logic [31:0]       running_total_q;
	logic [15:0]       x_low_q;
	logic [15:0]       bin_span_q;
	logic [6:0]        buckets_in_use_q;

	logic [1:0]        mode_q;
	logic [5:0]        sel_q;
	logic [5:0]        res_idx_q;
	logic [31:0]       res_cnt_q;
	logic              res_oor_q;
	logic [31:0]       res_tot_q;
	logic [39:0]       res_mean_q;
	logic [AW-1:0]     acc_q;
	logic [AW-1:0]     aux_q;
	logic [RW+1:0]     rem_q;
	logic [RW-1:0]     root_q;
	logic [S1W-1:0]    mpl_q;
	logic [S1W-1:0]    s1_q;
	logic [S2W-1:0]    s2_q;
	logic [SQW-1:0]    sq_q;

	logic              item_acc;
	logic              last;
	logic              sweep_last;
	logic [NW-1:0]     n_eff;
	logic [15:0]       w_eff;
	logic [15:0]       div_d;
	logic [15:0]       diff;
	logic              sel_in_range;
	logic              idx_in_range;
	logic              cnt_full;
	logic [31:0]       s1_sat;
	logic [RW+1:0]     r_div;
	logic [RW+1:0]     r_sqrt;
	logic [AW-1:0]     add_a;
	logic [AW-1:0]     add_b;
	logic              add_sub;
	logic [AW:0]       add_res;
	logic              ge;
	logic [AW-1:0]     quot_next;
	result_t           fin_result;

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic [IW-1:0]     mem_raddr;
	logic [COUNT_BITS-1:0] mem_rdata;

	hbs_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_BUCKETS)
	) u_counts (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;

	assign n_eff = (32'(buckets_in_use_q) > 32'(MAX_BUCKETS)) ? NW'(MAX_BUCKETS)
		: NW'(buckets_in_use_q);
	assign w_eff        = (bin_span_q == '0) ? 16'd1 : bin_span_q;
	assign div_d        = (state_q == ST_BIN_DIV) ? w_eff : 16'(n_eff);
	assign diff         = item.sample - x_low_q;
	assign sel_in_range = 16'(item.bucket_select) < 16'(n_eff);
	assign idx_in_range = acc_q[15:0] < 16'(n_eff);
	assign cnt_full     = (mem_rdata == '1);
	assign last         = (cnt_q == CW'(1));
	assign sweep_last   = (ptr_q == n_eff - NW'(1));
	assign s1_sat       = (AW'(s1_q) > AW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(s1_q);
	assign r_div        = {rem_q[RW:0], acc_q[AW-1]};
	assign r_sqrt       = {rem_q[RW-1:0], acc_q[AW-1:AW-2]};

	// shared add/subtract unit
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_BIN_DIV, ST_MEAN_DIV, ST_DIV_N1, ST_DIV_N2: begin
				add_a   = AW'(r_div);
				add_b   = AW'(div_d);
				add_sub = 1'b1;
			end
			ST_SQRT: begin
				add_a   = AW'(r_sqrt);
				add_b   = AW'({root_q, 2'b01});
				add_sub = 1'b1;
			end
			ST_MUL_N: begin
				add_a = {acc_q[AW-2:0], 1'b0};
				add_b = mpl_q[S1W-1] ? AW'(s2_q) : '0;
			end
			ST_MUL_S1: begin
				add_a = {acc_q[AW-2:0], 1'b0};
				add_b = mpl_q[S1W-1] ? AW'(s1_q) : '0;
			end
			ST_NUM_SUB: begin
				add_a   = aux_q;
				add_b   = acc_q;
				add_sub = 1'b1;
			end
			ST_SW_SUM1: begin
				add_a = AW'(s1_q);
				add_b = AW'(mem_rdata);
			end
			ST_SW_SUM2: begin
				add_a = AW'(s2_q);
				add_b = AW'(sq_q);
			end
			ST_BIN_INC: begin
				add_a = AW'(mem_rdata);
				add_b = AW'(1'b1);
			end
			default: begin
			end
		endcase
		add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b}) : ({1'b0, add_a} + {1'b0, add_b});
	end

	assign ge        = !add_res[AW];
	assign quot_next = {acc_q[AW-2:0], ge};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = acc_q[IW-1:0];
		mem_wdata = add_res[COUNT_BITS-1:0];
		mem_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[IW-1:0];
				mem_wdata = '0;
			end
			ST_BIN_INC:  mem_we    = !cnt_full;
			ST_BIN_READ: mem_raddr = acc_q[IW-1:0];
			ST_RD_WAIT:  mem_raddr = IW'(sel_q);
			ST_SW_ADDR:  mem_raddr = ptr_q[IW-1:0];
			default: begin
			end
		endcase
	end

	always_comb begin
		fin_result = '0;
		if (mode_q == MODE_REPORT) begin
			fin_result.total_count   = res_tot_q;
			fin_result.mean_count    = res_mean_q;
			fin_result.std_deviation = 40'(root_q);
		end else begin
			fin_result.bucket_index  = res_idx_q;
			fin_result.bucket_count  = res_cnt_q;
			fin_result.out_of_range  = res_oor_q;
			fin_result.total_count   = running_total_q;
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_X_LOW:          prdata = 32'(x_low_q);
			REG_BIN_SPAN:       prdata = 32'(bin_span_q);
			REG_BUCKETS_IN_USE: prdata = 32'(buckets_in_use_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			init_q           <= 1'b1;
			ptr_q            <= '0;
			cnt_q            <= '0;
			result_valid_q   <= 1'b0;
			result_q         <= '0;
			running_total_q  <= '0;
			x_low_q          <= X_LOW_RST;
			bin_span_q       <= BIN_SPAN_RST;
			buckets_in_use_q <= BUCKETS_IN_USE_RST;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_X_LOW:          x_low_q          <= pwdata[15:0];
					REG_BIN_SPAN:       bin_span_q       <= pwdata[15:0];
					REG_BUCKETS_IN_USE: buckets_in_use_q <= pwdata[6:0];
					default: begin
					end
				endcase
			end

			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			cnt_q <= cnt_q - CW'(1);

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						ptr_q <= '0;
						case (item.mode)
							MODE_SAMPLE: begin
								cnt_q   <= CW'(16);
								state_q <= (item.sample < x_low_q) ? ST_FIN : ST_BIN_DIV;
							end
							MODE_CLEAR: begin
								running_total_q <= '0;
								state_q         <= ST_CLEAR;
							end
							MODE_READ: state_q <= sel_in_range ? ST_RD_WAIT : ST_FIN;
							MODE_REPORT: state_q <= (n_eff == '0) ? ST_FIN : ST_SW_ADDR;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + NW'(1);
					if (ptr_q == NW'(MAX_BUCKETS - 1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_FIN;
					end
				end
				ST_BIN_DIV: begin
					if (last) begin
						state_q <= ST_BIN_CHECK;
					end
				end
				ST_BIN_CHECK: state_q <= idx_in_range ? ST_BIN_READ : ST_FIN;
				ST_BIN_READ:  state_q <= ST_BIN_INC;
				ST_BIN_INC: begin
					if (!cnt_full && running_total_q != 32'hFFFF_FFFF) begin
						running_total_q <= running_total_q + 32'd1;
					end
					state_q <= ST_FIN;
				end
				ST_RD_WAIT: state_q <= ST_RD_TAKE;
				ST_RD_TAKE: state_q <= ST_FIN;
				ST_SW_ADDR: state_q <= ST_SW_SUM1;
				ST_SW_SUM1: state_q <= ST_SW_SUM2;
				ST_SW_SUM2: begin
					ptr_q <= ptr_q + NW'(1);
					if (sweep_last) begin
						cnt_q   <= CW'(MW);
						state_q <= ST_MEAN_DIV;
					end else begin
						state_q <= ST_SW_ADDR;
					end
				end
				ST_MEAN_DIV: begin
					if (last) begin
						cnt_q   <= CW'(NW);
						state_q <= ST_MUL_N;
					end
				end
				ST_MUL_N: begin
					if (last) begin
						cnt_q   <= CW'(S1W);
						state_q <= ST_MUL_S1;
					end
				end
				ST_MUL_S1: begin
					if (last) begin
						state_q <= ST_NUM_SUB;
					end
				end
				ST_NUM_SUB: begin
					cnt_q   <= CW'(AW);
					state_q <= ST_DIV_N1;
				end
				ST_DIV_N1: begin
					if (last) begin
						cnt_q   <= CW'(AW);
						state_q <= ST_DIV_N2;
					end
				end
				ST_DIV_N2: begin
					if (last) begin
						cnt_q   <= CW'(RW);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!result_valid_q || !result_stall) begin
						result_q       <= fin_result;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					mode_q     <= item.mode;
					sel_q      <= item.bucket_select;
					res_idx_q  <= (item.mode == MODE_READ) ? item.bucket_select : '0;
					res_cnt_q  <= '0;
					res_oor_q  <= ((item.mode == MODE_SAMPLE) && (item.sample < x_low_q)) ||
						((item.mode == MODE_READ) && !sel_in_range);
					res_tot_q  <= '0;
					res_mean_q <= '0;
					root_q     <= '0;
					rem_q      <= '0;
					s1_q       <= '0;
					s2_q       <= '0;
					acc_q      <= AW'(diff) << (AW - 16);
				end
			end
			ST_BIN_DIV, ST_DIV_N1: begin
				rem_q <= ge ? add_res[RW+1:0] : r_div;
				acc_q <= quot_next;
				if (last) begin
					rem_q <= '0;
				end
			end
			ST_DIV_N2: begin
				rem_q <= ge ? add_res[RW+1:0] : r_div;
				acc_q <= quot_next;
				if (last) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_MEAN_DIV: begin
				rem_q <= ge ? add_res[RW+1:0] : r_div;
				acc_q <= quot_next;
				if (last) begin
					res_mean_q <= 40'(quot_next);
					acc_q      <= '0;
					mpl_q      <= S1W'(n_eff) << (S1W - NW);
				end
			end
			ST_BIN_CHECK: begin
				if (!idx_in_range) begin
					res_oor_q <= 1'b1;
				end
			end
			ST_BIN_INC: begin
				res_idx_q <= acc_q[5:0];
				res_cnt_q <= cnt_full ? 32'(mem_rdata) : 32'(add_res[COUNT_BITS-1:0]);
			end
			ST_RD_TAKE: res_cnt_q <= 32'(mem_rdata);
			ST_SW_SUM1: begin
				s1_q <= add_res[S1W-1:0];
				sq_q <= SQW'(mem_rdata) * SQW'(mem_rdata);
			end
			ST_SW_SUM2: begin
				s2_q <= add_res[S2W-1:0];
				if (sweep_last) begin
					acc_q     <= AW'({s1_q, 8'h00}) << (AW - MW);
					rem_q     <= '0;
					res_tot_q <= s1_sat;
				end
			end
			ST_MUL_N: begin
				acc_q <= add_res[AW-1:0];
				mpl_q <= mpl_q << 1;
				if (last) begin
					aux_q <= add_res[AW-1:0];
					acc_q <= '0;
					mpl_q <= s1_q;
				end
			end
			ST_MUL_S1: begin
				acc_q <= add_res[AW-1:0];
				mpl_q <= mpl_q << 1;
			end
			ST_NUM_SUB: begin
				acc_q <= add_res[AW-1:0] << 16;
				rem_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= ge ? add_res[RW+1:0] : r_sqrt;
				root_q <= {root_q[RW-2:0], ge};
				acc_q  <= acc_q << 2;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> item_stall)
		else $error("item accepted but block not busy next cycle");

	a_init_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (item_stall && !result_valid_q))
		else $error("item or result moved during reset clearing pass");

	a_mem_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_BIN_INC))
		else $error("bucket memory written outside clear or update");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT || state_q == ST_DIV_N1 || state_q == ST_DIV_N2 ||
		 state_q == ST_BIN_DIV) |-> (cnt_q != '0))
		else $error("iteration counter ran out");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && (!result_valid_q || !result_stall)) |=>
		(result_valid_q && state_q == ST_IDLE))
		else $error("finished transaction not loaded into result register");
`endif

endmodule

@@ rtl/hbs_ram.sv @@
module hbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ verif/histogram_binning_stats_tb.sv @@
`timescale 1ns / 100ps

module histogram_binning_stats_tb;
	import hbs_pkg::*;

	class bin_tracker;
		logic [31:0] counts [MAX_BUCKETS_DEF];
		logic [31:0] total;
		logic [63:0] sum_sq;
		logic [15:0] x_low;
		logic [15:0] bin_span;
		logic [6:0]  buckets_in_use;
		result_t     awaited [$];
		int          mismatches;

		function new();
			foreach (counts[i]) counts[i] = '0;
			total = '0;
			sum_sq = '0;
			x_low = X_LOW_RST;
			bin_span = BIN_SPAN_RST;
			buckets_in_use = BUCKETS_IN_USE_RST;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] v);
			case (r)
			REG_X_LOW: x_low = v[15:0];
			REG_BIN_SPAN: bin_span = v[15:0];
			REG_BUCKETS_IN_USE: buckets_in_use = v[6:0];
			default: ;
			endcase
		endfunction

		function int unsigned active_buckets();
			return buckets_in_use > MAX_BUCKETS_DEF ? MAX_BUCKETS_DEF : buckets_in_use;
		endfunction

		function logic [63:0] isqrt(logic [127:0] v);
			logic [63:0] root;
			logic [63:0] cand;
			root = '0;
			for (int b = 63; b >= 0; b--) begin
				cand = root | (64'd1 << b);
				if ({64'd0, cand} * {64'd0, cand} <= v)
					root = cand;
			end
			return root;
		endfunction

		// one transaction in, one expected result out
		function void note_item(item_t it);
			result_t      r;
			int unsigned  n;
			int unsigned  w;
			int unsigned  idx;
			logic [63:0]  step_sq;
			logic [63:0]  s1;
			logic [127:0] s2;
			logic [127:0] num;
			r = '0;
			n = active_buckets();
			case (it.mode)
			MODE_SAMPLE: begin
				w = bin_span == 0 ? 1 : bin_span;
				idx = it.sample >= x_low ? (it.sample - x_low) / w : 0;
				if (it.sample < x_low || idx >= n) begin
					r.out_of_range = 1'b1;
				end else begin
					if (counts[idx] != 32'hFFFF_FFFF) begin
						step_sq = {31'd0, counts[idx], 1'b1};
						sum_sq = sum_sq > 64'hFFFF_FFFF_FFFF_FFFF - step_sq ?
							64'hFFFF_FFFF_FFFF_FFFF : sum_sq + step_sq;
						counts[idx] = counts[idx] + 1;
						if (total != 32'hFFFF_FFFF)
							total = total + 1;
					end
					r.bucket_index = idx[5:0];
					r.bucket_count = counts[idx];
				end
				r.total_count = total;
			end
			MODE_CLEAR: begin
				foreach (counts[i]) counts[i] = '0;
				total = '0;
				sum_sq = '0;
			end
			MODE_READ: begin
				r.bucket_index = it.bucket_select;
				if (it.bucket_select < n)
					r.bucket_count = counts[it.bucket_select];
				else
					r.out_of_range = 1'b1;
				r.total_count = total;
			end
			default: begin
				s1 = '0;
				s2 = '0;
				for (int i = 0; i < n; i++) begin
					s1 += counts[i];
					s2 += 128'(counts[i]) * 128'(counts[i]);
				end
				r.total_count = s1 > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s1[31:0];
				if (n != 0) begin
					num = (s2 * n - 128'(s1) * 128'(s1)) << 16;
					r.mean_count = 40'((s1 << 8) / n);
					r.std_deviation = 40'(isqrt(num / (128'(n) * 128'(n))));
				end
			end
			endcase
			awaited.push_back(r);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 50)
					$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				$error("result with no transaction outstanding: %p", got);
			end else begin
				want = awaited.pop_front();
				compare("bucket_index", want.bucket_index, got.bucket_index);
				compare("bucket_count", want.bucket_count, got.bucket_count);
				compare("out_of_range", want.out_of_range, got.out_of_range);
				compare("total_count", want.total_count, got.total_count);
				compare("mean_count", want.mean_count, got.mean_count);
				compare("std_deviation", want.std_deviation, got.std_deviation);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	item_t             item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	bit         tx_gaps = 1'b1;
	bit         rx_gaps = 1'b1;
	int         rx_hold = 0;
	bin_tracker tracker = new();

	histogram_binning_stats dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("histogram_binning_stats_tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			tracker.note_item(item);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(result);
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold = rx_hold - 1;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			rx_hold = $urandom_range(0, 9);
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_reg(r, v);
		@(posedge clk);
	endtask

	task automatic send(mode_t m, logic [15:0] s, logic [5:0] b);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{mode: m, sample: s, bucket_select: b};
		do @(posedge clk); while (item_stall);
	endtask

	// hold off until every outstanding transaction has returned
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send(MODE_REPORT, 16'd0, 6'd0);
		send(MODE_READ, 16'd0, 6'd0);
		send(MODE_READ, 16'd0, 6'd63);
		send(MODE_SAMPLE, 16'd0, 6'd0);
		send(MODE_SAMPLE, 16'd1, 6'd0);
		send(MODE_SAMPLE, 16'd99, 6'd0);
		send(MODE_SAMPLE, 16'd100, 6'd0);
		send(MODE_SAMPLE, 16'hFFFF, 6'd0);
		send(MODE_READ, 16'd0, 6'd49);
		send(MODE_REPORT, 16'd0, 6'd0);
		send(MODE_CLEAR, 16'hFFFF, 6'h3F);
		send(MODE_REPORT, 16'd0, 6'd0);
		settle();
		write_reg(REG_X_LOW, 32'd100);
		write_reg(REG_BIN_SPAN, 32'd1);
		write_reg(REG_BUCKETS_IN_USE, 32'd64);
		send(MODE_SAMPLE, 16'd99, 6'd0);
		send(MODE_SAMPLE, 16'd100, 6'd0);
		send(MODE_SAMPLE, 16'd163, 6'd0);
		send(MODE_SAMPLE, 16'd164, 6'd0);
		send(MODE_READ, 16'd0, 6'd63);
		send(MODE_REPORT, 16'd0, 6'd0);
		settle();
		// zero width acts as one, oversized bucket count clamps
		write_reg(REG_X_LOW, 32'hFFFF);
		write_reg(REG_BIN_SPAN, 32'd0);
		write_reg(REG_BUCKETS_IN_USE, 32'd127);
		send(MODE_SAMPLE, 16'hFFFF, 6'd0);
		send(MODE_SAMPLE, 16'hFFFE, 6'd0);
		send(MODE_REPORT, 16'd0, 6'd0);
		settle();
		write_reg(REG_BUCKETS_IN_USE, 32'd0);
		send(MODE_SAMPLE, 16'hFFFF, 6'd0);
		send(MODE_READ, 16'd0, 6'd0);
		send(MODE_REPORT, 16'd0, 6'd0);
		settle();
		// shrunk range keeps stored counts out of reads and reports
		write_reg(REG_X_LOW, 32'd0);
		write_reg(REG_BIN_SPAN, 32'hFFFF);
		write_reg(REG_BUCKETS_IN_USE, 32'd1);
		send(MODE_SAMPLE, 16'hFFFE, 6'd0);
		send(MODE_SAMPLE, 16'hFFFF, 6'd0);
		send(MODE_READ, 16'd0, 6'd63);
		send(MODE_REPORT, 16'd0, 6'd0);
	endtask

	task automatic random_config();
		logic [15:0] lo;
		logic [15:0] wd;
		logic [6:0]  nb;
		case ($urandom_range(0, 5))
		0: lo = 16'd0;
		1: lo = 16'hFFFF - 16'($urandom_range(0, 255));
		default: lo = 16'($urandom_range(0, 40000));
		endcase
		case ($urandom_range(0, 7))
		0: wd = 16'd0;
		1: wd = 16'hFFFF;
		2: wd = 16'd1;
		3: wd = 16'($urandom);
		default: wd = 16'($urandom_range(1, 64));
		endcase
		case ($urandom_range(0, 9))
		0: nb = 7'd0;
		1: nb = 7'($urandom_range(65, 127));
		2: nb = 7'd64;
		3: nb = 7'd1;
		default: nb = 7'($urandom_range(2, 64));
		endcase
		write_reg(REG_X_LOW, lo);
		write_reg(REG_BIN_SPAN, wd);
		write_reg(REG_BUCKETS_IN_USE, nb);
	endtask

	task automatic random_items(int count);
		int unsigned n;
		int unsigned w;
		int unsigned hi;
		int unsigned pick;
		logic [15:0] s;
		logic [5:0]  b;
		n = tracker.active_buckets();
		w = tracker.bin_span == 0 ? 1 : tracker.bin_span;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			s = 16'($urandom);
			b = 6'($urandom);
			if (pick < 70) begin
				if (n != 0 && $urandom_range(0, 4) != 0) begin
					hi = tracker.x_low + n * w - 1;
					if (hi > 65535)
						hi = 65535;
					s = 16'($urandom_range(hi, tracker.x_low));
				end
				send(MODE_SAMPLE, s, b);
			end else if (pick < 84) begin
				if (n != 0 && $urandom_range(0, 3) != 0)
					b = 6'($urandom_range(n - 1, 0));
				send(MODE_READ, s, b);
			end else if (pick < 97) begin
				send(MODE_REPORT, s, b);
			end else begin
				send(MODE_CLEAR, s, b);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int p = 0; p < 8; p++) begin
			if (p == 7) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			settle();
			random_config();
			random_items(110);
		end
		settle();
		repeat (600) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
			$display("histogram_binning_stats_tb: PASS");
		end else begin
			$display("histogram_binning_stats_tb: FAIL");
		end
		$finish;
	end

endmodule
